>>> hdl/ps2mpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared widths, constants and types for the packet tracker modules.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

	// Cursor coordinate width and the working width of the position arithmetic.
	localparam int COORD_BITS = 16;
	localparam int EXT_BITS   = COORD_BITS + 2;
	localparam int OUT_BITS   = 16;
	localparam int SIZE_BITS  = 14;

	// Saturation bounds of the signed coordinate range, at working width.
	localparam logic signed [EXT_BITS-1:0] COORD_MAX = {3'b000, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [EXT_BITS-1:0] COORD_MIN = {3'b111, {(COORD_BITS - 1){1'b0}}};

	// Header byte fields and the acknowledge code.
	localparam logic [7:0] ACK_BYTE  = 8'hFA;
	localparam int         SYNC_BIT  = 3;
	localparam int         XSIGN_BIT = 4;
	localparam int         YSIGN_BIT = 5;

	// Click box geometry.
	localparam int BOX_W   = 72;
	localparam int BOX_OFF = 36;
	localparam int BOX_H   = 28;
	localparam int BOX_PAD = 4;

	typedef enum logic [1:0] {
		REG_DISPLAY_ENABLED = 2'd0,
		REG_SCREEN_WIDTH    = 2'd1,
		REG_SCREEN_HEIGHT   = 2'd2
	} cfg_reg_t;

	// One complete three-byte packet.
	typedef struct packed {
		logic [7:0] hdr;
		logic [7:0] x_byte;
		logic [7:0] y_byte;
	} packet_t;

	typedef struct packed {
		logic                 display_enabled;
		logic [SIZE_BITS-1:0] screen_width;
		logic [SIZE_BITS-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] pos_x;
		logic signed [OUT_BITS-1:0] pos_y;
		logic [2:0]                 buttons;
		logic signed [8:0]          delta_x;
		logic signed [8:0]          delta_y;
		logic                       box_clicked;
	} result_t;

endpackage

>>> hdl/ps2mpt_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet framer
// Registers incoming bytes, filters the header and gathers three-byte packets.
// ----------------------------------------------------------------------------
module ps2mpt_framer import ps2mpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	output logic       pkt_valid,
	input  logic       pkt_ready,
	output packet_t    pkt
);

	typedef enum logic [2:0] {
		WAIT_HDR = 3'b001,
		WAIT_X   = 3'b010,
		WAIT_Y   = 3'b100
	} frame_state_t;

	frame_state_t state_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic [7:0]   hdr_q;
	logic [7:0]   x_byte_q;
	logic         advance;
	logic         hdr_ok;

	assign hdr_ok    = byte_s1[SYNC_BIT] && (byte_s1 != ACK_BYTE);
	assign pkt_valid = valid_s1 && (state_q == WAIT_Y);
	assign advance   = valid_s1 && ((state_q != WAIT_Y) || pkt_ready);
	assign s_tready  = !valid_s1 || advance;

	assign pkt.hdr    = hdr_q;
	assign pkt.x_byte = x_byte_q;
	assign pkt.y_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= WAIT_HDR;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				unique case (state_q)
					WAIT_HDR: begin
						if (hdr_ok) begin
							state_q <= WAIT_X;
						end
					end
					WAIT_X:  state_q <= WAIT_Y;
					WAIT_Y:  state_q <= WAIT_HDR;
					default: state_q <= WAIT_HDR;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance && (state_q == WAIT_HDR) && hdr_ok) begin
			hdr_q <= byte_s1;
		end
		if (advance && (state_q == WAIT_X)) begin
			x_byte_q <= byte_s1;
		end
	end

	// A filtered byte in the header slot never starts a packet.
	a_hdr_filter: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (state_q == WAIT_HDR) && !hdr_ok |=> state_q == WAIT_HDR)
		else $error("framer left header wait on a filtered byte");

	// A packet offered to the tracker is held until it is taken.
	a_pkt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_ready |=> pkt_valid && $stable(byte_s1))
		else $error("framer dropped a waiting packet");

endmodule

>>> hdl/ps2mpt_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Applies a packet to the cursor, clamps it and holds the result word.
// ----------------------------------------------------------------------------
module ps2mpt_tracker import ps2mpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    pkt_valid,
	output logic    pkt_ready,
	input  packet_t pkt,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	logic signed [COORD_BITS-1:0] cursor_x_q;
	logic signed [COORD_BITS-1:0] cursor_y_q;
	logic [2:0]                   buttons_q;
	logic                         res_valid_q;
	result_t                      res_q;

	logic signed [8:0]          dx;
	logic signed [8:0]          dy;
	logic signed [EXT_BITS-1:0] nx;
	logic signed [EXT_BITS-1:0] ny;
	logic signed [EXT_BITS-1:0] w_max;
	logic signed [EXT_BITS-1:0] h_max;
	logic signed [EXT_BITS-1:0] cx;
	logic signed [EXT_BITS-1:0] cy;
	logic signed [EXT_BITS-1:0] sx;
	logic signed [EXT_BITS-1:0] sy;
	logic signed [EXT_BITS-1:0] fx;
	logic signed [EXT_BITS-1:0] fy;
	logic signed [EXT_BITS-1:0] box_top;
	logic signed [EXT_BITS-1:0] box_bot;
	logic                       in_box;
	logic                       clicked;
	logic                       take;

	assign pkt_ready = !res_valid_q || res_ready;
	assign take      = pkt_valid && pkt_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		dx = $signed({pkt.hdr[XSIGN_BIT], pkt.x_byte});
		dy = $signed({pkt.hdr[YSIGN_BIT], pkt.y_byte});
		nx = EXT_BITS'(cursor_x_q) + EXT_BITS'(dx);
		ny = EXT_BITS'(cursor_y_q) - EXT_BITS'(dy);

		// A zero screen size behaves as a size of one.
		w_max = (cfg.screen_width == '0) ? '0 :
			$signed(EXT_BITS'(cfg.screen_width)) - EXT_BITS'(1);
		h_max = (cfg.screen_height == '0) ? '0 :
			$signed(EXT_BITS'(cfg.screen_height)) - EXT_BITS'(1);

		// Screen clamp; the result is never negative, so only the top bound remains.
		cx = (nx < 0) ? '0 : ((nx > w_max) ? w_max : nx);
		cy = (ny < 0) ? '0 : ((ny > h_max) ? h_max : ny);
		cx = (cx > COORD_MAX) ? COORD_MAX : cx;
		cy = (cy > COORD_MAX) ? COORD_MAX : cy;

		sx = (nx > COORD_MAX) ? COORD_MAX : ((nx < COORD_MIN) ? COORD_MIN : nx);
		sy = (ny > COORD_MAX) ? COORD_MAX : ((ny < COORD_MIN) ? COORD_MIN : ny);

		fx = cfg.display_enabled ? cx : sx;
		fy = cfg.display_enabled ? cy : sy;

		box_top = h_max + EXT_BITS'(1) - EXT_BITS'(BOX_OFF - BOX_PAD);
		box_bot = box_top + EXT_BITS'(BOX_H);
		in_box  = (cx >= EXT_BITS'(BOX_PAD)) && (cx <= EXT_BITS'(BOX_PAD + BOX_W)) &&
			(cy >= box_top) && (cy <= box_bot);
		clicked = cfg.display_enabled && pkt.hdr[0] && !buttons_q[0] && in_box;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			buttons_q   <= '0;
		end else begin
			if (pkt_ready) begin
				res_valid_q <= pkt_valid;
			end
			if (take) begin
				cursor_x_q <= fx[COORD_BITS-1:0];
				cursor_y_q <= fy[COORD_BITS-1:0];
				buttons_q  <= pkt.hdr[2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.pos_x       <= fx[OUT_BITS-1:0];
			res_q.pos_y       <= fy[OUT_BITS-1:0];
			res_q.buttons     <= pkt.hdr[2:0];
			res_q.delta_x     <= dx;
			res_q.delta_y     <= dy;
			res_q.box_clicked <= clicked;
		end
	end

	// Every packet taken shows up as a result word on the next cycle.
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_valid_q)
		else $error("packet taken without a result word");

	// A click needs the left button down in this packet.
	a_click_left: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.box_clicked |-> res_q.buttons[0])
		else $error("click reported without left button");

	// The stored cursor follows the reported position.
	a_cursor_match: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_q.pos_x == cursor_x_q[OUT_BITS-1:0] &&
			res_q.pos_y == cursor_y_q[OUT_BITS-1:0])
		else $error("cursor and result word disagree");

endmodule

>>> hdl/ps2_mouse_packet_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker core
// Decodes three-byte PS/2 mouse packets into cursor position and buttons.
// ----------------------------------------------------------------------------
// The core takes one mouse byte per word on the slave stream and gives one
// result word per completed three-byte packet on the master stream. A byte
// is taken in every cycle unless the input register holds a waiting third
// byte: it enters that register, and the framing, sign extension, cursor
// update and clamp all sit in logic between it and the result register. A
// result waiting for the master side holds only the third byte of a following
// packet; header and X bytes keep flowing. In the header slot, bytes with bit
// 3 clear and the 0xFA acknowledge are dropped; bits 6 and 7 of the header are
// ignored. With the display enabled, the cursor is held inside the screen and
// a new left press inside the click box near the bottom-left corner sets
// box_clicked; with it disabled, the cursor saturates at the signed 16-bit
// range. A screen size of zero acts as one. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while no packet
// is in flight, which the block does not enforce. Writes to an unused index
// are ignored. There is no clearing pass after reset.
module ps2_mouse_packet_tracker_core import ps2mpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [SIZE_BITS-1:0] cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [15:0] pos_x, [31:16] pos_y, [34:32] buttons, [43:35] delta_x,
	// [52:44] delta_y, [53] box_clicked, [55:54] zero
	output logic [55:0]          m_tdata
);

	cfg_t    cfg_q;
	packet_t pkt;
	logic    pkt_valid;
	logic    pkt_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_enabled <= 1'b0;
			cfg_q.screen_width    <= SIZE_BITS'(640);
			cfg_q.screen_height   <= SIZE_BITS'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DISPLAY_ENABLED: cfg_q.display_enabled <= cfg_data[0];
				REG_SCREEN_WIDTH:    cfg_q.screen_width    <= cfg_data;
				REG_SCREEN_HEIGHT:   cfg_q.screen_height   <= cfg_data;
				default: ;
			endcase
		end
	end

	ps2mpt_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

	ps2mpt_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {2'b00, res.box_clicked, res.delta_y, res.delta_x, res.buttons,
		res.pos_y, res.pos_x};

endmodule
